// File: sv/square_region_color_stats_macros.svh
// Assertion helpers for the RTL.
`ifndef SQUARE_REGION_COLOR_STATS_MACROS_SVH
`define SQUARE_REGION_COLOR_STATS_MACROS_SVH

// Clocked check, masked while reset is held.
`define SRCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SRCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/srcs_pkg.sv
`timescale 1ns / 1ps
package srcs_pkg;

  localparam int MAX_SIDE_LOG2_DEF = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE    = 2'd1;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] corner_x;
    logic [5:0] corner_y;
    logic [2:0] size_log2;
  } srcs_in_t;

  typedef struct packed {
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [29:0] variance;
    logic [1:0]  status;
  } srcs_out_t;

  // control of the shared square/accumulate unit
  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } srcs_sq_ctl_t;

endpackage

// File: sv/srcs_table_mem.sv
`timescale 1ns / 1ps
module srcs_table_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 147
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/srcs_sq_acc.sv
`timescale 1ns / 1ps
module srcs_sq_acc
  import srcs_pkg::*;
#(
  parameter int IN_W = 20
) (
  input  logic                clk,
  input  srcs_sq_ctl_t        ctl,
  input  logic [IN_W-1:0]     operand,
  output logic [2*IN_W+1:0]   sum
);

  logic [2*IN_W-1:0] prod_r;
  logic [2*IN_W+1:0] sum_r;

  // square is registered before it reaches the adder
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= operand * operand;
    end
    if (ctl.clr) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_r + (2*IN_W+2)'(prod_r);
    end
  end

  assign sum = sum_r;

endmodule

// File: sv/square_region_color_stats.sv
`timescale 1ns / 1ps
// Channel  Ports                          Direction  Moves
// in       in_valid in_stall in_data      input      one command word
// out      out_valid out_stall out_data   output     one query result word
// cfg      cfg_valid cfg_ready cfg_index  input      one register write word
//          cfg_data
//
// Steps: a load accepts the word, reads the entry above, then writes the new
// entry; a load past the image end is accepted and has no effect. A query
// reads four corners through the single table read port, then makes three
// passes through the shared squarer, then gives the result; a rejected query
// goes straight to the result. Reset is synchronous, active low; the tables
// are not cleared. out_stall only holds a query in its result state while an
// earlier result still waits in the output register.
module square_region_color_stats
  import srcs_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  srcs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output srcs_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  `include "square_region_color_stats_macros.svh"

  localparam int P    = MAX_SIDE_LOG2;
  localparam int SW   = 8 + 2*P;               // channel sum entry
  localparam int QW   = 16 + 2*P;              // squared sum entry
  localparam int WW   = 3*SW + 3*QW;           // one table word, all six tables
  localparam int EW   = ((P > 6) ? P : 6) + 2; // room for corner + side and dims
  localparam int SSW  = 2*SW + 2;              // summed squared sums
  localparam int VW   = (SSW > 30) ? SSW : 30;
  localparam int AW   = 2*P;

  typedef enum logic [2:0] {
    S_IDLE, S_LRD, S_LWR, S_QRD, S_QACC, S_MUL, S_MACC, S_DONE
  } state_t;

  state_t state_r;

  logic [6:0]   width_r, height_r;
  logic [P-1:0] load_col_r;
  logic [P:0]   load_row_r;
  logic         loaded_r;

  logic [EW-1:0] w_eff, h_eff;

  // pixel and its squares
  logic [7:0]  pix_r [3];
  logic [15:0] pix_sq_r [3];

  // load neighbors: last word written (left) and last word read above (diagonal)
  logic [WW-1:0] last_wr_r, prev_up_r;

  // query
  logic [P-1:0] x0_r, y0_r, x1_r, y1_r;
  logic         zx_r, zy_r;
  logic [2:0]   k_r;
  logic [1:0]   qc_r;
  logic [1:0]   ch_r;
  logic [1:0]   stat_r;
  logic [WW-1:0] acc_r;

  logic         out_valid_r;
  srcs_out_t    out_r;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  // squarer
  srcs_sq_ctl_t  sq_ctl;
  logic [SW-1:0] sq_operand;
  logic [SSW-1:0] sum_sq;

  logic accept, cfg_we;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  // register writes only land between words
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective dims: 0 acts as 1, above the max side acts as the max side
  always_comb begin
    w_eff = EW'(width_r);
    h_eff = EW'(height_r);
    if (w_eff == '0) w_eff = EW'(1);
    if (w_eff > (EW'(1) << P)) w_eff = EW'(1) << P;
    if (h_eff == '0) h_eff = EW'(1);
    if (h_eff > (EW'(1) << P)) h_eff = EW'(1) << P;
  end

  // ---------------- load datapath ----------------
  logic [WW-1:0] up_w, left_w, diag_w, new_w;
  always_comb begin
    up_w   = (load_row_r != '0) ? mem_rdata : '0;
    left_w = (load_col_r != '0) ? last_wr_r : '0;
    diag_w = ((load_row_r != '0) && (load_col_r != '0)) ? prev_up_r : '0;
    for (int c = 0; c < 3; c++) begin
      new_w[c*SW +: SW] = SW'(pix_r[c]) + up_w[c*SW +: SW] + left_w[c*SW +: SW]
                          - diag_w[c*SW +: SW];
      new_w[3*SW + c*QW +: QW] = QW'(pix_sq_r[c]) + up_w[3*SW + c*QW +: QW]
                                 + left_w[3*SW + c*QW +: QW]
                                 - diag_w[3*SW + c*QW +: QW];
    end
  end

  // ---------------- query corner read address ----------------
  // corner order: bottom-right (+), above (-), left (-), above-left (+)
  logic [P-1:0] rd_row, rd_col;
  logic         corner_zero, corner_neg;
  always_comb begin
    rd_row = y1_r;
    rd_col = x1_r;
    corner_zero = 1'b0;
    corner_neg  = 1'b0;
    case (qc_r)
      2'd0: begin
        rd_row = y1_r;
        rd_col = x1_r;
      end
      2'd1: begin
        rd_row = y0_r - P'(1);
        rd_col = x1_r;
        corner_zero = zy_r;
        corner_neg  = 1'b1;
      end
      2'd2: begin
        rd_row = y1_r;
        rd_col = x0_r - P'(1);
        corner_zero = zx_r;
        corner_neg  = 1'b1;
      end
      default: begin
        rd_row = y0_r - P'(1);
        rd_col = x0_r - P'(1);
        corner_zero = zx_r || zy_r;
      end
    endcase
  end

  always_comb begin
    mem_raddr = (state_r == S_LRD) ? {P'(load_row_r - (P+1)'(1)), load_col_r}
                                   : {rd_row, rd_col};
    mem_we    = (state_r == S_LWR);
    mem_waddr = {load_row_r[P-1:0], load_col_r};
    mem_wdata = new_w;
  end

  srcs_table_mem #(
    .ADDR_W (AW),
    .DATA_W (WW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------- shared squarer ----------------
  always_comb begin
    sq_ctl.clr = (state_r == S_IDLE);
    sq_ctl.mul = (state_r == S_MUL);
    sq_ctl.acc = (state_r == S_MACC);
    sq_operand = acc_r[SW-1:0];
    case (ch_r)
      2'd1:    sq_operand = acc_r[SW +: SW];
      2'd2:    sq_operand = acc_r[2*SW +: SW];
      default: sq_operand = acc_r[SW-1:0];
    endcase
  end

  srcs_sq_acc #(
    .IN_W (SW)
  ) u_sq (
    .clk     (clk),
    .ctl     (sq_ctl),
    .operand (sq_operand),
    .sum     (sum_sq)
  );

  // ---------------- query input checks ----------------
  logic [EW-1:0] q_side, q_cx, q_cy, q_x1, q_y1;
  logic          q_outside;
  always_comb begin
    q_side = EW'(1) << in_data.size_log2;
    q_cx   = EW'(in_data.corner_x);
    q_cy   = EW'(in_data.corner_y);
    q_x1   = q_cx + q_side - EW'(1);
    q_y1   = q_cy + q_side - EW'(1);
    q_outside = (32'(in_data.size_log2) > P) || (q_cx + q_side > w_eff)
                || (q_cy + q_side > h_eff);
  end

  // ---------------- result ----------------
  srcs_out_t     res;
  logic [QW+1:0] sq_total;
  logic [VW-1:0] var_full;
  logic [3:0]    shamt;
  always_comb begin
    shamt    = {k_r, 1'b0};
    sq_total = (QW+2)'(acc_r[3*SW +: QW]) + (QW+2)'(acc_r[3*SW + QW +: QW])
               + (QW+2)'(acc_r[3*SW + 2*QW +: QW]);
    var_full = VW'(sq_total) - VW'(sum_sq >> shamt);
    res.avg_red   = 8'(acc_r[SW-1:0] >> shamt);
    res.avg_green = 8'(acc_r[SW +: SW] >> shamt);
    res.avg_blue  = 8'(acc_r[2*SW +: SW] >> shamt);
    res.variance  = var_full[29:0];
    res.status    = stat_r;
    if (stat_r != STAT_OK) begin
      res.avg_red   = '0;
      res.avg_green = '0;
      res.avg_blue  = '0;
      res.variance  = '0;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= 7'd64;
      height_r    <= 7'd64;
      load_col_r  <= '0;
      load_row_r  <= '0;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      qc_r        <= '0;
      ch_r        <= '0;
    end else begin
      // S_DONE sets or keeps the flag itself
      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            for (int c = 0; c < 3; c++) begin
              acc_r[c*SW +: SW] <= '0;
              acc_r[3*SW + c*QW +: QW] <= '0;
            end
            pix_r[0]    <= in_data.red;
            pix_r[1]    <= in_data.green;
            pix_r[2]    <= in_data.blue;
            pix_sq_r[0] <= in_data.red * in_data.red;
            pix_sq_r[1] <= in_data.green * in_data.green;
            pix_sq_r[2] <= in_data.blue * in_data.blue;
            k_r  <= in_data.size_log2;
            x0_r <= q_cx[P-1:0];
            y0_r <= q_cy[P-1:0];
            x1_r <= q_x1[P-1:0];
            y1_r <= q_y1[P-1:0];
            zx_r <= (in_data.corner_x == '0);
            zy_r <= (in_data.corner_y == '0);
            qc_r <= '0;
            ch_r <= '0;
            if (in_data.command == CMD_LOAD) begin
              if (!loaded_r && (EW'(load_row_r) < h_eff)) state_r <= S_LRD;
            end else if (!loaded_r) begin
              stat_r  <= STAT_NOT_LOADED;
              state_r <= S_DONE;
            end else if (q_outside) begin
              stat_r  <= STAT_OUTSIDE;
              state_r <= S_DONE;
            end else begin
              stat_r  <= STAT_OK;
              state_r <= S_QRD;
            end
          end
        end
        S_LRD: state_r <= S_LWR;
        S_LWR: begin
          last_wr_r <= new_w;
          prev_up_r <= up_w;
          if (EW'(load_col_r) + EW'(1) >= w_eff) begin
            load_col_r <= '0;
            load_row_r <= load_row_r + (P+1)'(1);
            if (EW'(load_row_r) + EW'(1) >= h_eff) loaded_r <= 1'b1;
          end else begin
            load_col_r <= load_col_r + P'(1);
          end
          state_r <= S_IDLE;
        end
        S_QRD: state_r <= S_QACC;
        S_QACC: begin
          if (!corner_zero) begin
            for (int c = 0; c < 3; c++) begin
              acc_r[c*SW +: SW] <= corner_neg
                ? acc_r[c*SW +: SW] - mem_rdata[c*SW +: SW]
                : acc_r[c*SW +: SW] + mem_rdata[c*SW +: SW];
              acc_r[3*SW + c*QW +: QW] <= corner_neg
                ? acc_r[3*SW + c*QW +: QW] - mem_rdata[3*SW + c*QW +: QW]
                : acc_r[3*SW + c*QW +: QW] + mem_rdata[3*SW + c*QW +: QW];
            end
          end
          qc_r    <= qc_r + 2'd1;
          state_r <= (qc_r == 2'd3) ? S_MUL : S_QRD;
        end
        S_MUL: state_r <= S_MACC;
        S_MACC: begin
          ch_r    <= ch_r + 2'd1;
          state_r <= (ch_r == 2'd2) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          // hold while an older result still sits unclaimed
          if (!out_valid_r || !out_stall) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // width or height write restarts loading
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            width_r    <= cfg_data;
            load_col_r <= '0;
            load_row_r <= '0;
            loaded_r   <= 1'b0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_r   <= cfg_data;
            load_col_r <= '0;
            load_row_r <= '0;
            loaded_r   <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- checks ----------------
  `SRCS_ASSERT(a_query_busy, accept && (in_data.command == CMD_QUERY) |=> in_stall, "query did not occupy sequencer")
  `SRCS_ASSERT(a_row_bound, EW'(load_row_r) <= h_eff, "load row passed image height")
  `SRCS_ASSERT(a_loaded_row, loaded_r |-> (EW'(load_row_r) == h_eff), "loaded flag without full image")

endmodule
